// ===== sv/btpl_pkg.sv =====
package btpl_pkg;

    // default node table depth
    localparam int unsigned DEF_NODE_DEPTH = 65536;

    // fixed field widths
    localparam int CHILD_W    = 17;
    localparam int NODE_IDX_W = 16;
    localparam int ADDR_W     = 32;
    localparam int STATUS_W   = 2;
    localparam int LEVEL_W    = $clog2(ADDR_W);
    localparam int ENTRY_W    = 2 * CHILD_W;

    // action codes of an input word
    localparam logic ACT_WRITE  = 1'b0;
    localparam logic ACT_LOOKUP = 1'b1;

    // result codes
    typedef enum logic [STATUS_W-1:0] {
        STATUS_FOUND     = 2'd0,
        STATUS_NOT_FOUND = 2'd1,
        STATUS_EXHAUSTED = 2'd2
    } status_t;

    // commands from controller to datapath
    typedef struct packed {
        logic write_node;
        logic start_walk;
        logic step;
        logic report;
    } dp_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic terminal;
        logic found;
    } dp_stat_t;

endpackage

// ===== sv/btpl_ctrl.sv =====
module btpl_ctrl
    import btpl_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  logic     action,
    input  dp_stat_t stat,
    output logic     busy,
    output dp_cmd_t  cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_WALK = 2'b10
    } state_t;

    state_t               state_reg;
    state_t               state_next;
    logic [LEVEL_W-1:0]   level_reg;
    logic [LEVEL_W-1:0]   level_next;

    // sequencing of one lookup, one trie level per cycle
    always_comb
    begin
        state_next = state_reg;
        level_next = level_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (action == ACT_LOOKUP)
                    begin
                        cmd.start_walk = 1'b1;
                        level_next     = LEVEL_W'(ADDR_W - 1);
                        state_next     = ST_WALK;
                    end
                    else
                    begin
                        cmd.write_node = 1'b1;
                    end
                end
            end
            ST_WALK:
            begin
                if (stat.terminal || (level_reg == '0))
                begin
                    cmd.report = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.step   = 1'b1;
                    level_next = level_reg - 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and level registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            level_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            level_reg <= level_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

// ===== sv/btpl_datapath.sv =====
module btpl_datapath
    import btpl_pkg::*;
#(
    parameter int unsigned NODE_DEPTH = DEF_NODE_DEPTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  dp_cmd_t               cmd,
    output dp_stat_t              stat,
    input  logic [NODE_IDX_W-1:0] node_index,
    input  logic [CHILD_W-1:0]    left_child,
    input  logic [CHILD_W-1:0]    right_child,
    input  logic [ADDR_W-1:0]     address,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CHILD_W-1:0]    cfg_data,
    output logic                  done,
    output logic [STATUS_W-1:0]   status
);

    localparam int IDX_W = (NODE_DEPTH > 1) ? $clog2(NODE_DEPTH) : 1;

    logic [ENTRY_W-1:0]  node_mem [NODE_DEPTH];
    logic [ENTRY_W-1:0]  rd_data_reg;
    logic                oob_reg;
    logic                oob_next;
    logic [IDX_W-1:0]    rd_addr;
    logic [CHILD_W-1:0]  node_count_reg;
    logic [ADDR_W-1:0]   addr_reg;
    logic [ENTRY_W-1:0]  entry;
    logic [CHILD_W-1:0]  child_next;
    logic                wr_ok;
    status_t             status_reg;
    status_t             status_next;
    logic                done_reg;

    // node count register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            node_count_reg <= cfg_data;
        end
    end

    // child chosen by the current address bit; entries past the table read as zero
    assign entry      = oob_reg ? '0 : rd_data_reg;
    assign child_next = addr_reg[ADDR_W-1] ? entry[ENTRY_W-1:CHILD_W] : entry[CHILD_W-1:0];

    assign stat.terminal = (child_next >= node_count_reg);
    assign stat.found    = (child_next > node_count_reg);

    // next read: root on a new lookup, else the chosen child
    always_comb
    begin
        if (cmd.start_walk)
        begin
            rd_addr  = '0;
            oob_next = 1'b0;
        end
        else
        begin
            rd_addr  = IDX_W'(child_next);
            oob_next = (32'(child_next) >= 32'(NODE_DEPTH));
        end
    end

    // write accepted up to and including the node count, inside the table
    assign wr_ok = ({1'b0, node_index} <= node_count_reg)
                && (32'(node_index) < 32'(NODE_DEPTH));

    // node table
    always_ff @(posedge clk)
    begin
        if (cmd.write_node && wr_ok)
        begin
            node_mem[IDX_W'(node_index)] <= {right_child, left_child};
        end
        rd_data_reg <= node_mem[rd_addr];
        oob_reg     <= oob_next;
    end

    // address shifter, top bit is the current level
    always_ff @(posedge clk)
    begin
        if (cmd.start_walk)
        begin
            addr_reg <= address;
        end
        else if (cmd.step)
        begin
            addr_reg <= {addr_reg[ADDR_W-2:0], 1'b0};
        end
    end

    // result word
    always_comb
    begin
        if (!stat.terminal)
        begin
            status_next = STATUS_EXHAUSTED;
        end
        else if (stat.found)
        begin
            status_next = STATUS_FOUND;
        end
        else
        begin
            status_next = STATUS_NOT_FOUND;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.report)
        begin
            status_reg <= status_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.report;
        end
    end

    assign done   = done_reg;
    assign status = status_reg;

endmodule

// ===== sv/binary_trie_prefix_lookup_core.sv =====
// Binary trie prefix lookup over a node table of NODE_DEPTH entries.
// Input words are taken at a rising edge with start high and busy low.
// A write word (action 0) loads left_child/right_child at node_index in
// that same edge; it gives no result and busy stays low, so a write can
// follow every cycle. Writes above the node count are dropped.
// A lookup word (action 1) walks address from its top bit, one trie level
// per cycle: the node table read port with its registered output sets the
// pace. The walk ends at a terminal child or after the last address bit, and
// the result passes through a result register; busy is high meanwhile.
// status (0 found, 1 not found, 2 walk exhausted) is valid for exactly one
// cycle with done high; there is no back-pressure, the receiver must take
// it. A new word may be started in the cycle done is shown.
// The node count register is written over cfg_valid/cfg_ready (always
// ready) and should only change while idle.
// Reset clears the controller, the result strobe and the node count; the
// node table is not cleared and each entry is undefined until written.
module binary_trie_prefix_lookup_core
    import btpl_pkg::*;
#(
    parameter int unsigned NODE_DEPTH = DEF_NODE_DEPTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  action,
    input  logic [NODE_IDX_W-1:0] node_index,
    input  logic [CHILD_W-1:0]    left_child,
    input  logic [CHILD_W-1:0]    right_child,
    input  logic [ADDR_W-1:0]     address,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CHILD_W-1:0]    cfg_data,
    output logic                  done,
    output logic [STATUS_W-1:0]   status
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // sequencer
    btpl_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .action (action),
        .stat   (stat),
        .busy   (busy),
        .cmd    (cmd)
    );

    // node table, walk registers and result
    btpl_datapath #(
        .NODE_DEPTH (NODE_DEPTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .node_index  (node_index),
        .left_child  (left_child),
        .right_child (right_child),
        .address     (address),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .done        (done),
        .status      (status)
    );

endmodule

// ===== sv/btpl_checker.sv =====
module btpl_checker
    import btpl_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input logic                busy,
    input logic                action,
    input logic                done,
    input logic [STATUS_W-1:0] status
);

    // a lookup word makes the block busy
    a_lookup_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (action == ACT_LOOKUP)) |=> busy)
        else $error("lookup accepted without going busy");

    // a write word gives no result and keeps the block free
    a_write_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (action == ACT_WRITE)) |=> (!busy && !done))
        else $error("write word changed busy or gave a result");

    // the result word appears exactly when a lookup finishes
    a_done_end: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $fell(busy))
        else $error("result strobe without end of lookup");

    a_end_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("lookup ended without result strobe");

    // result code is one of the three defined codes
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((status == STATUS_FOUND) || (status == STATUS_NOT_FOUND)
                  || (status == STATUS_EXHAUSTED)))
        else $error("undefined result code");

endmodule

bind binary_trie_prefix_lookup_core btpl_checker u_btpl_checker (.*);

// ===== tb/tb_binary_trie_prefix_lookup_core.sv =====
module tb_binary_trie_prefix_lookup_core;
    import btpl_pkg::*;

    localparam int CLK_HI       = 6;
    localparam int CLK_LO       = 6;
    localparam int RESET_CYCLES = 6;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 40;
    localparam int TREE_NODES   = 16;
    localparam int PHASE_ITEMS  = 135;
    localparam int RAND_PHASES  = 14;
    localparam int CHILD_TOP    = (1 << CHILD_W) - 1;
    localparam int IDX_TOP      = (1 << NODE_IDX_W) - 1;

    // one input word as the driver presents it
    typedef struct packed {
        logic                  act;
        logic [NODE_IDX_W-1:0] idx;
        logic [CHILD_W-1:0]    lchild;
        logic [CHILD_W-1:0]    rchild;
        logic [ADDR_W-1:0]     addr;
    } trie_word_t;

    logic                  clk;
    logic                  rst_n       = 1'b0;
    logic                  start       = 1'b0;
    logic                  busy;
    logic                  action      = ACT_WRITE;
    logic [NODE_IDX_W-1:0] node_index  = '0;
    logic [CHILD_W-1:0]    left_child  = '0;
    logic [CHILD_W-1:0]    right_child = '0;
    logic [ADDR_W-1:0]     address     = '0;
    logic                  cfg_valid   = 1'b0;
    logic                  cfg_ready;
    logic [CHILD_W-1:0]    cfg_data    = '0;
    logic                  done;
    logic [STATUS_W-1:0]   status;

    // words waiting for the driver and lookups waiting for their status
    trie_word_t pending_words[$];
    status_t    expected_status[$];

    int words_queued = 0;
    int words_driven = 0;
    int words_taken  = 0;
    int gap_left     = 0;
    int gap_max      = 7;
    int fail_cnt     = 0;
    int idle_cycles  = 0;

    // predicted node table and node count
    logic [ENTRY_W-1:0] trie_mem [DEF_NODE_DEPTH];
    logic [CHILD_W-1:0] node_cnt = '0;

    // stimulus bookkeeping: which entries hold data, current trie shape
    bit node_written [DEF_NODE_DEPTH];
    int written_prefix = 0;
    int gen_cnt        = 0;
    int tree_nodes     = 1;
    bit tree_mode      = 1'b0;
    int node_pct       = 50;

    binary_trie_prefix_lookup_core i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .action      (action),
        .node_index  (node_index),
        .left_child  (left_child),
        .right_child (right_child),
        .address     (address),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .done        (done),
        .status      (status)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #CLK_LO;
        clk = 1'b1;
        #CLK_HI;
    end

    // reset, once at the start
    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    end

    // walk the predicted table from node 0, top address bit first
    function automatic status_t trie_walk(logic [ADDR_W-1:0] addr);
        logic [CHILD_W-1:0] node;
        logic [CHILD_W-1:0] nxt;
        logic [ENTRY_W-1:0] entry;
        node = '0;
        for (int lvl = ADDR_W - 1; lvl >= 0; lvl--)
        begin
            entry = (node < DEF_NODE_DEPTH) ? trie_mem[node[NODE_IDX_W-1:0]] : '0;
            nxt = addr[lvl] ? entry[ENTRY_W-1:CHILD_W] : entry[CHILD_W-1:0];
            if (nxt == node_cnt)
                return STATUS_NOT_FOUND;
            if (nxt > node_cnt)
                return STATUS_FOUND;
            node = nxt;
        end
        return STATUS_EXHAUSTED;
    endfunction

    // driver: next word at the falling edge once the current one is taken
    always @(negedge clk)
    begin
        trie_word_t w;
        logic       holding;
        if (rst_n)
        begin
            holding = start && (words_taken != words_driven);
            if (!holding)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    start <= 1'b0;
                end
                else if (pending_words.size() != 0)
                begin
                    w = pending_words.pop_front();
                    action      <= w.act;
                    node_index  <= w.idx;
                    left_child  <= w.lchild;
                    right_child <= w.rchild;
                    address     <= w.addr;
                    words_driven++;
                    gap_left = $urandom_range(0, gap_max);
                    start <= 1'b1;
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor: check results, predict accepted words, watch for a hang
    always @(posedge clk)
    begin
        status_t want;
        logic    moved;
        if (rst_n)
        begin
            moved = 1'b0;
            if (done)
            begin
                moved = 1'b1;
                if (expected_status.size() == 0)
                begin
                    $error("status: result with no lookup outstanding, expected none, actual %0d",
                           status);
                    fail_cnt++;
                end
                else
                begin
                    want = expected_status.pop_front();
                    if (status !== want)
                    begin
                        $error("status mismatch: expected %0d, actual %0d", want, status);
                        fail_cnt++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                moved = 1'b1;
                node_cnt = cfg_data;
            end
            if (start && !busy)
            begin
                moved = 1'b1;
                words_taken++;
                if (action == ACT_LOOKUP)
                    expected_status.push_back(trie_walk(address));
                else if (node_index <= node_cnt)
                    trie_mem[node_index] = {right_child, left_child};
            end
            if (moved)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("tb_binary_trie_prefix_lookup_core: FAIL");
                $finish;
            end
        end
    end

    // queue one word and track which table entries now hold data
    task automatic push_word(logic act, int idx, int lc, int rc, logic [ADDR_W-1:0] a);
        trie_word_t w;
        w.act    = act;
        w.idx    = NODE_IDX_W'(idx);
        w.lchild = CHILD_W'(lc);
        w.rchild = CHILD_W'(rc);
        w.addr   = a;
        pending_words.push_back(w);
        words_queued++;
        if (act == ACT_WRITE && idx <= gen_cnt)
        begin
            node_written[idx] = 1'b1;
            while (written_prefix < DEF_NODE_DEPTH && node_written[written_prefix])
                written_prefix++;
        end
    endtask

    // wait until every word is taken and every lookup has answered
    task automatic wait_idle();
        @(negedge clk);
        while (words_taken != words_queued || expected_status.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // new node count, written only while the block is idle
    task automatic begin_phase(int cnt);
        wait_idle();
        cfg_data  <= CHILD_W'(cnt);
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        gen_cnt = cnt;
    endtask

    // child index: a real node, the empty marker, or a match marker
    function automatic int pick_child();
        int r;
        r = $urandom_range(0, 99);
        if (r < node_pct && gen_cnt > 0)
            return tree_mode ? $urandom_range(0, tree_nodes - 1) : $urandom_range(0, gen_cnt - 1);
        if (r < node_pct + 12 || gen_cnt >= CHILD_TOP)
            return gen_cnt;
        if (!tree_mode && r >= 95)
            return $urandom_range(0, CHILD_TOP);
        return $urandom_range(gen_cnt + 1, CHILD_TOP);
    endfunction

    function automatic int pick_index();
        int r;
        int v;
        r = $urandom_range(0, 99);
        if (r < 55)
            return tree_mode ? $urandom_range(0, tree_nodes - 1)
                             : $urandom_range(0, (gen_cnt < 63) ? gen_cnt : 63);
        if (r < 70)
        begin
            v = gen_cnt - 1 + $urandom_range(0, 2);
            return (v < 0) ? 0 : ((v > IDX_TOP) ? IDX_TOP : v);
        end
        return $urandom_range(0, IDX_TOP);
    endfunction

    function automatic logic [ADDR_W-1:0] pick_address();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return '0;
        if (r < 20)
            return '1;
        if (r < 35)
            return $urandom() >> $urandom_range(0, 31);
        return $urandom();
    endfunction

    // one random phase: rebuild a small trie if needed, then mixed words
    task automatic run_phase(int cnt, int n_items);
        begin_phase(cnt);
        tree_mode  = (cnt > written_prefix);
        tree_nodes = (cnt < TREE_NODES) ? ((cnt < 1) ? 1 : cnt) : TREE_NODES;
        if (tree_mode)
            for (int i = 0; i < tree_nodes; i++)
                push_word(ACT_WRITE, i, pick_child(), pick_child(), $urandom());
        for (int i = 0; i < n_items; i++)
        begin
            if ($urandom_range(0, 99) < 35)
                push_word(ACT_WRITE, pick_index(), pick_child(), pick_child(), $urandom());
            else
                push_word(ACT_LOOKUP, $urandom_range(0, IDX_TOP), $urandom_range(0, CHILD_TOP),
                          $urandom_range(0, CHILD_TOP), pick_address());
        end
    endtask

    // stimulus
    initial
    begin
        int cnt;
        wait (rst_n === 1'b1);

        // empty table: every child of node 0 is terminal
        begin_phase(0);
        push_word(ACT_WRITE, 0, 0, CHILD_TOP, '0);
        push_word(ACT_LOOKUP, 0, 0, 0, 32'h0000_0000);
        push_word(ACT_LOOKUP, 0, 0, 0, 32'hFFFF_FFFF);
        push_word(ACT_WRITE, 1, CHILD_TOP, CHILD_TOP, '0);
        push_word(ACT_LOOKUP, 0, 0, 0, 32'h8000_0000);

        // left chain through all twelve nodes loops back to node 0
        begin_phase(12);
        for (int i = 0; i < 12; i++)
            push_word(ACT_WRITE, i, (i == 11) ? 0 : i + 1, 12 + (i % 2), '0);
        push_word(ACT_LOOKUP, 0, 0, 0, 32'h0000_0000);
        push_word(ACT_LOOKUP, 0, 0, 0, 32'hFFFF_FFFF);
        push_word(ACT_LOOKUP, 0, 0, 0, 32'h4000_0000);

        // write at the node count lands, writes above it are dropped
        begin_phase(3);
        push_word(ACT_WRITE, 3, 12, 14, '0);
        push_word(ACT_WRITE, 5, CHILD_TOP, CHILD_TOP, '0);
        push_word(ACT_WRITE, IDX_TOP, CHILD_TOP, CHILD_TOP, '0);
        push_word(ACT_LOOKUP, 0, 0, 0, 32'h0000_0000);

        // back to twelve nodes: node 3 changed, node 5 did not
        begin_phase(12);
        push_word(ACT_LOOKUP, 0, 0, 0, 32'h0000_0000);
        push_word(ACT_WRITE, 0, 1, 5, '0);
        push_word(ACT_LOOKUP, 0, 0, 0, 32'h8000_0000);

        // random phases over several node counts, extremes first
        for (int p = 0; p < RAND_PHASES; p++)
        begin
            case (p)
                0: cnt = 65536;
                1: cnt = 1;
                2: cnt = 65535;
                3: cnt = 2;
                4: cnt = 0;
                5: cnt = 16;
                default: cnt = (p % 2) ? $urandom_range(1, 40) : $urandom_range(0, 65536);
            endcase
            gap_max  = (p % 4 == 3) ? 0 : 7;
            node_pct = (p % 2) ? 85 : 50;
            run_phase(cnt, PHASE_ITEMS);
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_cnt == 0)
            $display("tb_binary_trie_prefix_lookup_core: PASS");
        else
            $display("tb_binary_trie_prefix_lookup_core: FAIL");
        $finish;
    end

endmodule
